@@ hw/rtl/stable_priority_queue_defines.svh @@
// Assertion macros shared by the queue RTL.
// They expand to concurrent assertions in simulation and to nothing in synthesis.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only while the block is out of reset.
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(label, clk, rst_n, prop, msg)
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ hw/rtl/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

    // Fixed field widths of the transactions.
    localparam int VALUE_W     = 32;
    localparam int IN_PRIO_W   = 8;
    localparam int TOTAL_W     = 36;
    localparam int COUNT_OUT_W = 5;

    // Action codes; codes above ACT_STATUS behave as a status request.
    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_STATUS = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_DROPPED_FULL = 2'd1,
        ST_REMOVE_EMPTY = 2'd2
    } status_t;

    // Input transaction.
    typedef struct packed {
        logic [2:0]                 action;
        logic signed [VALUE_W-1:0]  item_value;
        logic [IN_PRIO_W-1:0]       item_priority;
    } item_t;

    // Result transaction.
    typedef struct packed {
        logic signed [VALUE_W-1:0]  out_value;
        logic                       had_item;
        logic [COUNT_OUT_W-1:0]     entry_count;
        logic signed [TOTAL_W-1:0]  total;
        logic                       is_empty;
        logic                       is_full;
        logic [1:0]                 status;
    } result_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic write_en;  // place the new entry somewhere in the chain
        logic by_prio;   // placement by priority rather than at the tail
        logic remove;    // shift the whole chain one place toward the head
    } cell_ctl_t;

endpackage

@@ hw/rtl/spq_cell.sv @@
`timescale 1ns / 1ps

// One storage slot of the queue. Slot IDX sits IDX places behind the head.
module spq_cell #(
    parameter int IDX           = 0,
    parameter int PRIORITY_BITS = 8,
    parameter int COUNT_W       = 5
) (
    input  logic                                 clk,
    input  spq_pkg::cell_ctl_t                   ctl,
    input  logic [COUNT_W-1:0]                   count,
    input  logic signed [spq_pkg::VALUE_W-1:0]   new_value,
    input  logic [PRIORITY_BITS-1:0]             new_prio,
    input  logic signed [spq_pkg::VALUE_W-1:0]   left_value,
    input  logic [PRIORITY_BITS-1:0]             left_prio,
    input  logic signed [spq_pkg::VALUE_W-1:0]   right_value,
    input  logic [PRIORITY_BITS-1:0]             right_prio,
    input  logic                                 found_in,
    output logic                                 found_out,
    output logic signed [spq_pkg::VALUE_W-1:0]   value,
    output logic [PRIORITY_BITS-1:0]             prio,
    output logic signed [spq_pkg::VALUE_W-1:0]   value_next
);

    logic signed [spq_pkg::VALUE_W-1:0] value_reg;
    logic [PRIORITY_BITS-1:0]           prio_reg;
    logic [PRIORITY_BITS-1:0]           prio_next;
    logic                               occupied;
    logic                               candidate;
    logic                               hit;

    // The slot holds an entry when it lies below the fill count.
    assign occupied  = count > COUNT_W'(IDX);

    // The new entry lands in the first slot that is empty or, when placing by
    // priority, holds a strictly lower priority. Equal priorities stay ahead.
    assign candidate = ctl.write_en &&
                       (!occupied || (ctl.by_prio && (prio_reg < new_prio)));
    assign hit       = candidate && !found_in;
    assign found_out = found_in || candidate;

    // Slot update: shift toward the head, shift away from the insertion
    // point, take the new entry, or hold.
    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        priority if (ctl.remove)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
        else if (found_in && ctl.write_en)
        begin
            value_next = left_value;
            prio_next  = left_prio;
        end
        else if (hit)
        begin
            value_next = new_value;
            prio_next  = new_prio;
        end
    end

    // Payload registers need no reset; unread slots may hold anything.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

@@ hw/rtl/stable_priority_queue.sv @@
`timescale 1ns / 1ps
// A result appears in the output register in the cycle after its transaction is accepted.
// One transaction per cycle unless a finished result is held up; every slot of the cell chain
// compares and shifts in parallel, so insert, remove, append, clear and status all keep that rate.
// Reset clears the fill count, the running sum and the result valid flag at once.
// Slot contents are not cleared; only slots below the fill count are ever read.

`include "stable_priority_queue_defines.svh"

module stable_priority_queue #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  spq_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output spq_pkg::result_t result
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;
    logic signed [spq_pkg::TOTAL_W-1:0]  sum_reg;
    logic signed [spq_pkg::TOTAL_W-1:0]  sum_next;
    logic                                result_valid_reg;
    logic                                result_valid_next;
    spq_pkg::result_t                    result_reg;
    spq_pkg::result_t                    result_next;

    logic                                accept;
    logic                                full;
    logic                                empty;
    logic                                add_act;
    logic                                removed;
    logic [1:0]                          status;
    logic [PRIORITY_BITS-1:0]            new_prio;
    spq_pkg::cell_ctl_t                  ctl;

    logic signed [spq_pkg::VALUE_W-1:0]  cell_value [DEPTH];
    logic signed [spq_pkg::VALUE_W-1:0]  cell_value_next [DEPTH];
    logic [PRIORITY_BITS-1:0]            cell_prio [DEPTH];
    logic                                found [DEPTH+1];

    // A new transaction is taken unless a finished result is still held up.
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    assign full     = count_reg == CW'(DEPTH);
    assign empty    = count_reg == '0;
    assign new_prio = PRIORITY_BITS'(item.item_priority);

    // Append and insert both add an entry.
    assign add_act  = (item.action == spq_pkg::ACT_APPEND) ||
                      (item.action == spq_pkg::ACT_INSERT);

    // Command for the cell chain.
    always_comb
    begin
        ctl.write_en = accept && !full && add_act;
        ctl.by_prio  = item.action == spq_pkg::ACT_INSERT;
        ctl.remove   = accept && !empty && (item.action == spq_pkg::ACT_REMOVE);
    end

    assign removed = ctl.remove;

    // Fill count, running sum and status code.
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        status     = spq_pkg::ST_OK;
        unique case (item.action)
            spq_pkg::ACT_APPEND, spq_pkg::ACT_INSERT:
            begin
                if (full)
                begin
                    status = spq_pkg::ST_DROPPED_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + spq_pkg::TOTAL_W'(item.item_value);
                end
            end
            spq_pkg::ACT_REMOVE:
            begin
                if (empty)
                begin
                    status = spq_pkg::ST_REMOVE_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    sum_next   = sum_reg - spq_pkg::TOTAL_W'(cell_value[0]);
                end
            end
            spq_pkg::ACT_CLEAR:
            begin
                count_next = '0;
                sum_next   = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Result: the removed entry on a remove, else the head, plus the queue state after the action.
    always_comb
    begin
        result_next.out_value   = '0;
        result_next.had_item    = 1'b0;
        if (removed)
        begin
            result_next.out_value = cell_value[0];
            result_next.had_item  = 1'b1;
        end
        else if (count_next != '0)
        begin
            result_next.out_value = cell_value_next[0];
            result_next.had_item  = 1'b1;
        end
        result_next.entry_count = spq_pkg::COUNT_OUT_W'(count_next);
        result_next.total       = sum_next;
        result_next.is_empty    = count_next == '0;
        result_next.is_full     = count_next == CW'(DEPTH);
        result_next.status      = status;
    end

    // The output register frees up when its result is taken.
    always_comb
    begin
        result_valid_next = result_valid_reg;
        priority if (accept)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The chain of slots; the insertion point ripples from head to tail.
    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [spq_pkg::VALUE_W-1:0] left_value;
        logic [PRIORITY_BITS-1:0]           left_prio;
        logic signed [spq_pkg::VALUE_W-1:0] right_value;
        logic [PRIORITY_BITS-1:0]           right_prio;

        // The head never takes from the left; on a remove the tail takes the new item, beyond the fill count.
        if (i == 0)
        begin : g_head
            assign left_value = item.item_value;
            assign left_prio  = new_prio;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
            assign left_prio  = cell_prio[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_value = item.item_value;
            assign right_prio  = new_prio;
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
            assign right_prio  = cell_prio[i+1];
        end

        spq_cell #(
            .IDX           (i),
            .PRIORITY_BITS (PRIORITY_BITS),
            .COUNT_W       (CW)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .count       (count_reg),
            .new_value   (item.item_value),
            .new_prio    (new_prio),
            .left_value  (left_value),
            .left_prio   (left_prio),
            .right_value (right_value),
            .right_prio  (right_prio),
            .found_in    (found[i]),
            .found_out   (found[i+1]),
            .value       (cell_value[i]),
            .prio        (cell_prio[i]),
            .value_next  (cell_value_next[i])
        );
    end

    // Checks on the queue control.
    `SPQ_ASSERT_ALWAYS(a_count_bound, clk,
        !rst_n || (count_reg <= CW'(DEPTH)),
        "fill count above capacity")
    `SPQ_ASSERT(a_full_drop, clk, rst_n,
        accept && full && add_act
        |=> $stable(count_reg) && (result_reg.status == spq_pkg::ST_DROPPED_FULL),
        "insert into full queue changed state")
    `SPQ_ASSERT(a_empty_remove, clk, rst_n,
        accept && empty && (item.action == spq_pkg::ACT_REMOVE)
        |=> result_valid_reg && !result_reg.had_item
            && (result_reg.status == spq_pkg::ST_REMOVE_EMPTY),
        "remove on empty queue misreported")
    `SPQ_ASSERT(a_clear, clk, rst_n,
        accept && (item.action == spq_pkg::ACT_CLEAR) |=> (count_reg == '0) && (sum_reg == '0),
        "clear left entries behind")
    `SPQ_ASSERT(a_place_found, clk, rst_n,
        ctl.write_en |-> found[DEPTH],
        "new entry found no slot")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int QUEUE_DEPTH      = 16;
    localparam int PRIO_BITS        = 8;
    localparam int RANDOM_PER_PHASE = 395;
    localparam int BIAS_RUN         = 40;
    localparam int SETTLE_CYCLES    = 8;

    // Codes five to seven are spare and must act like a status request.
    localparam logic [2:0] FIRST_SPARE_ACTION = 3'd5;
    localparam logic [2:0] LAST_SPARE_ACTION  = 3'd7;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    spq_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    spq_pkg::result_t result;

    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Shadow copy of the queue contents, head at index zero.
    logic signed [spq_pkg::VALUE_W-1:0] shadow_value [QUEUE_DEPTH];
    logic [spq_pkg::IN_PRIO_W-1:0]      shadow_prio [QUEUE_DEPTH];
    int                                 shadow_count = 0;
    logic signed [spq_pkg::TOTAL_W-1:0] shadow_sum = '0;

    // Reports owed by the block, oldest first.
    spq_pkg::result_t awaited_reports[$];

    // One row of the directed sequence.
    typedef struct {
        spq_pkg::item_t   stim;
        int               copies;
        bit               typed;
        spq_pkg::result_t want;
    } plan_row_t;

    plan_row_t plan[$];

    stable_priority_queue #(
        .DEPTH         (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIO_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Apply one action to the shadow queue and return the report it should produce.
    function automatic spq_pkg::result_t apply_action(spq_pkg::item_t it);
        spq_pkg::result_t r;
        spq_pkg::status_t st;
        int               pos;
        bit               took;
        r = '0;
        st = spq_pkg::ST_OK;
        took = 1'b0;
        case (it.action)
            spq_pkg::ACT_APPEND, spq_pkg::ACT_INSERT:
            begin
                if (shadow_count >= QUEUE_DEPTH)
                begin
                    st = spq_pkg::ST_DROPPED_FULL;
                end
                else
                begin
                    pos = shadow_count;
                    // Stable insert: go after every entry of greater or equal priority.
                    if (it.action == spq_pkg::ACT_INSERT)
                    begin
                        for (int i = 0; i < shadow_count; i++)
                        begin
                            if (pos == shadow_count && shadow_prio[i] < it.item_priority)
                                pos = i;
                        end
                    end
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_value[i] = shadow_value[i-1];
                        shadow_prio[i]  = shadow_prio[i-1];
                    end
                    shadow_value[pos] = it.item_value;
                    shadow_prio[pos]  = it.item_priority;
                    shadow_count++;
                    shadow_sum = shadow_sum + {{4{it.item_value[31]}}, it.item_value};
                end
            end
            spq_pkg::ACT_REMOVE:
            begin
                if (shadow_count == 0)
                begin
                    st = spq_pkg::ST_REMOVE_EMPTY;
                end
                else
                begin
                    r.out_value = shadow_value[0];
                    r.had_item = 1'b1;
                    took = 1'b1;
                    shadow_sum = shadow_sum - {{4{shadow_value[0][31]}}, shadow_value[0]};
                    shadow_count--;
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        shadow_value[i] = shadow_value[i+1];
                        shadow_prio[i]  = shadow_prio[i+1];
                    end
                end
            end
            spq_pkg::ACT_CLEAR:
            begin
                shadow_count = 0;
                shadow_sum = '0;
            end
            default:
            begin
            end
        endcase
        // Anything but a successful remove reports the head after the action.
        if (!took && shadow_count > 0)
        begin
            r.out_value = shadow_value[0];
            r.had_item = 1'b1;
        end
        r.entry_count = 5'(shadow_count);
        r.total = shadow_sum;
        r.is_empty = (shadow_count == 0);
        r.is_full = (shadow_count == QUEUE_DEPTH);
        r.status = st;
        return r;
    endfunction

    function automatic spq_pkg::result_t make_report(logic [31:0] v, logic had,
                                                     logic [4:0] cnt, logic [35:0] tot,
                                                     logic empty, logic full,
                                                     spq_pkg::status_t st);
        spq_pkg::result_t r;
        r.out_value = v;
        r.had_item = had;
        r.entry_count = cnt;
        r.total = tot;
        r.is_empty = empty;
        r.is_full = full;
        r.status = st;
        return r;
    endfunction

    function automatic void add_row(logic [2:0] act, logic [31:0] v, logic [7:0] p,
                                    int copies, bit typed, spq_pkg::result_t want);
        plan_row_t row;
        row.stim.action = act;
        row.stim.item_value = v;
        row.stim.item_priority = p;
        row.copies = copies;
        row.typed = typed;
        row.want = want;
        plan.push_back(row);
    endfunction

    // Random action; the fill bias leans toward growing the queue so it often runs full.
    function automatic spq_pkg::item_t random_item(bit fill_bias);
        spq_pkg::item_t it;
        int             pick;
        pick = $urandom_range(0, 99);
        if (pick < (fill_bias ? 40 : 25))
            it.action = spq_pkg::ACT_INSERT;
        else if (pick < (fill_bias ? 58 : 35))
            it.action = spq_pkg::ACT_APPEND;
        else if (pick < 90)
            it.action = spq_pkg::ACT_REMOVE;
        else if (pick < 92)
            it.action = spq_pkg::ACT_CLEAR;
        else if (pick < 96)
            it.action = spq_pkg::ACT_STATUS;
        else
            it.action = 3'($urandom_range(FIRST_SPARE_ACTION, LAST_SPARE_ACTION));
        case ($urandom_range(0, 7))
            0: it.item_value = 32'h7FFF_FFFF;
            1: it.item_value = 32'h8000_0000;
            2: it.item_value = $urandom_range(0, 511) - 256;
            default: it.item_value = $urandom;
        endcase
        // Few distinct priorities make ties common, which exercises the stable order.
        if ($urandom_range(0, 1))
            it.item_priority = 8'($urandom_range(0, 3));
        else
            it.item_priority = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Offer one transaction, with an optional random gap first, and record its report.
    task automatic send_item(input spq_pkg::item_t it, input bit typed,
                             input spq_pkg::result_t want);
        spq_pkg::result_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        predicted = apply_action(it);
        awaited_reports.push_back(typed ? want : predicted);
    endtask

    // Hold the sender off until every owed report has come back.
    task automatic wait_for_reports();
        item_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
    endtask

    function automatic void compare_field(string label, logic [35:0] want, logic [35:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            errors++;
        end
    endfunction

    // Result side: check accepted reports and stall at random.
    always @(posedge clk)
    begin
        spq_pkg::result_t want;
        if (rst_n && result_valid === 1'b1 && !result_stall)
        begin
            if (awaited_reports.size() == 0)
            begin
                $display("%0t ns: unexpected report, expected none, actual %h", $time, result);
                errors++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                compare_field("out_value", 36'(want.out_value), 36'(result.out_value));
                compare_field("had_item", 36'(want.had_item), 36'(result.had_item));
                compare_field("entry_count", 36'(want.entry_count), 36'(result.entry_count));
                compare_field("total", want.total, result.total);
                compare_field("is_empty", 36'(want.is_empty), 36'(result.is_empty));
                compare_field("is_full", 36'(want.is_full), 36'(result.is_full));
                compare_field("status", 36'(want.status), 36'(result.status));
            end
        end
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Main sequence: directed rows, then three random phases with different idling.
    initial
    begin
        bit fill_bias;
        fill_bias = 1'b0;

        // Empty queue, status and remove on empty.
        add_row(spq_pkg::ACT_STATUS, 32'h0, 8'h00, 1, 1'b1,
                make_report(32'h0, 1'b0, 5'd0, 36'h0, 1'b1, 1'b0, spq_pkg::ST_OK));
        add_row(spq_pkg::ACT_REMOVE, 32'h0, 8'h00, 1, 1'b1,
                make_report(32'h0, 1'b0, 5'd0, 36'h0, 1'b1, 1'b0, spq_pkg::ST_REMOVE_EMPTY));
        // Extreme values; the high priority insert goes to the head.
        add_row(spq_pkg::ACT_APPEND, 32'h7FFF_FFFF, 8'h00, 1, 1'b1,
                make_report(32'h7FFF_FFFF, 1'b1, 5'd1, 36'h0_7FFF_FFFF, 1'b0, 1'b0,
                            spq_pkg::ST_OK));
        add_row(spq_pkg::ACT_INSERT, 32'h8000_0000, 8'hFF, 1, 1'b1,
                make_report(32'h8000_0000, 1'b1, 5'd2, 36'hF_FFFF_FFFF, 1'b0, 1'b0,
                            spq_pkg::ST_OK));
        // Ties keep arrival order; append ignores priority; a mid priority lands between.
        add_row(spq_pkg::ACT_INSERT, 32'h0000_0100, 8'hFF, 1, 1'b0, '0);
        add_row(spq_pkg::ACT_INSERT, 32'h0000_0055, 8'h00, 1, 1'b0, '0);
        add_row(spq_pkg::ACT_APPEND, 32'h0000_00AA, 8'h80, 1, 1'b0, '0);
        add_row(spq_pkg::ACT_INSERT, 32'h0000_0033, 8'h7F, 1, 1'b0, '0);
        add_row(spq_pkg::ACT_REMOVE, 32'h0, 8'h00, 1, 1'b0, '0);
        add_row(spq_pkg::ACT_REMOVE, 32'h0, 8'h00, 1, 1'b0, '0);
        // Spare codes leave the queue alone.
        add_row(FIRST_SPARE_ACTION, 32'hFFFF_FFFF, 8'hFF, 1, 1'b0, '0);
        add_row(FIRST_SPARE_ACTION + 3'd1, 32'h1234_5678, 8'h01, 1, 1'b0, '0);
        add_row(LAST_SPARE_ACTION, 32'h8000_0000, 8'h80, 1, 1'b0, '0);
        add_row(spq_pkg::ACT_CLEAR, 32'h0, 8'h00, 1, 1'b1,
                make_report(32'h0, 1'b0, 5'd0, 36'h0, 1'b1, 1'b0, spq_pkg::ST_OK));
        // Fill with the largest value for the top of the sum range, then overflow.
        add_row(spq_pkg::ACT_APPEND, 32'h7FFF_FFFF, 8'hAA, QUEUE_DEPTH, 1'b0, '0);
        add_row(spq_pkg::ACT_INSERT, 32'h0000_0001, 8'hFF, 1, 1'b1,
                make_report(32'h7FFF_FFFF, 1'b1, 5'd16, 36'h7_FFFF_FFF0, 1'b0, 1'b1,
                            spq_pkg::ST_DROPPED_FULL));
        add_row(spq_pkg::ACT_APPEND, 32'h0000_0001, 8'h00, 1, 1'b1,
                make_report(32'h7FFF_FFFF, 1'b1, 5'd16, 36'h7_FFFF_FFF0, 1'b0, 1'b1,
                            spq_pkg::ST_DROPPED_FULL));
        add_row(spq_pkg::ACT_CLEAR, 32'h0, 8'h00, 1, 1'b1,
                make_report(32'h0, 1'b0, 5'd0, 36'h0, 1'b1, 1'b0, spq_pkg::ST_OK));
        // Fill with the smallest value for the bottom of the sum range, then drain.
        add_row(spq_pkg::ACT_INSERT, 32'h8000_0000, 8'h55, QUEUE_DEPTH, 1'b0, '0);
        add_row(spq_pkg::ACT_STATUS, 32'h0, 8'h00, 1, 1'b1,
                make_report(32'h8000_0000, 1'b1, 5'd16, 36'h8_0000_0000, 1'b0, 1'b1,
                            spq_pkg::ST_OK));
        add_row(spq_pkg::ACT_REMOVE, 32'h0, 8'h00, QUEUE_DEPTH, 1'b0, '0);
        add_row(spq_pkg::ACT_REMOVE, 32'h0, 8'h00, 1, 1'b1,
                make_report(32'h0, 1'b0, 5'd0, 36'h0, 1'b1, 1'b0, spq_pkg::ST_REMOVE_EMPTY));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 21;
        recv_idle_pct = 62;
        foreach (plan[r])
        begin
            for (int k = 0; k < plan[r].copies; k++)
                send_item(plan[r].stim, plan[r].typed, plan[r].want);
        end
        wait_for_reports();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 62 : 0;
            recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 21 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n % BIAS_RUN == 0)
                    fill_bias = 1'($urandom_range(0, 1));
                send_item(random_item(fill_bias), 1'b0, '0);
            end
            wait_for_reports();
        end

        // Let any stray report show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
